// ----- sv/i2c_bitbang_read_lux_engine_top_macros.svh -----
// assertion macros for the i2c register read engine checker
// needs a clock i_clk and an active-low reset i_rst_n in the using scope
`ifndef I2C_BITBANG_READ_LUX_ENGINE_TOP_MACROS_SVH
`define I2C_BITBANG_READ_LUX_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define I2CRL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2crl assertion failed");

// next-cycle implication
`define I2CRL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("i2crl assertion failed");

`endif

// ----- sv/i2crl_pkg.sv -----
// shared types, constants and the lux term helper for the i2c read engine
// no dependencies
package i2crl_pkg;

    localparam int MAX_READ_BYTES_DEF = 256;
    localparam int CFG_DATA_W         = 16;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_COUNT_W        = 9;
    localparam int READ_MIN           = 4;
    localparam int WORD_BYTES         = 4;
    localparam int LUX_W              = 33;

    localparam logic [11:0] LUX_RECIP = 12'd3277;
    localparam logic [10:0] LUX_DIV   = 11'd5;

    // (256^k - 1) / 5 for byte positions of the word
    localparam logic [LUX_W-1:0] LUX_MOD_TAB [WORD_BYTES] = '{
        33'd0, 33'd51, 33'd13107, 33'd3355443
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEV_ADDR  = 2'd0,
        CFG_REG_IDX   = 2'd1,
        CFG_READ_CNT  = 2'd2,
        CFG_WAIT_PH   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        SEQ_IDLE   = 4'd0,
        SEQ_START  = 4'd1,
        SEQ_WADDR  = 4'd2,
        SEQ_REG    = 4'd3,
        SEQ_RSTART = 4'd4,
        SEQ_RADDR  = 4'd5,
        SEQ_WAIT   = 4'd6,
        SEQ_READ   = 4'd7,
        SEQ_STOP   = 4'd8
    } t_seq;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_op;

    typedef struct packed {
        logic op;
        logic sda_in;
    } t_in_word;

    typedef struct packed {
        logic             scl_level;
        logic             sda_level;
        logic             byte_valid;
        logic [7:0]       rx_byte;
        logic             lux_valid;
        logic [LUX_W-1:0] lux_value;
        logic             busy_res;
    } t_out_word;

    typedef struct packed {
        logic [LUX_W-1:0] add;
        logic [2:0]       rem;
    } t_lux_term;

    // byte b at position k adds 7*b*256^k = 5*add + rem
    function automatic t_lux_term lux_term(input logic [7:0] b, input logic [1:0] k);
        logic [10:0]      d;
        logic [22:0]      prod;
        logic [8:0]       t;
        logic [10:0]      r_full;
        logic [LUX_W-1:0] sh;
        t_lux_term        res;
        d      = {b, 3'b000} - {3'b000, b};
        prod   = {12'd0, d} * {11'd0, LUX_RECIP};
        t      = prod[22:14];
        r_full = d - ({2'b00, t} * LUX_DIV);
        sh     = {24'd0, t} << {k, 3'b000};
        res.rem = r_full[2:0];
        res.add = sh + ({30'd0, r_full[2:0]} * LUX_MOD_TAB[k]);
        return res;
    endfunction

endpackage

// ----- sv/i2c_bitbang_read_lux_engine_top.sv -----
// i2c master register read engine, one bus phase per input word; uses i2crl_pkg
// each result word is registered and shown in the cycle after its input word is taken
// throughput: one input word per cycle while the result side keeps up
// lux is accumulated for each of the first four received bytes by quotient and remainder by five, the
// cycle after the byte completes, long before the stop phase reports it
// synchronous active-low reset: idle, lines released, config registers at defaults
module i2c_bitbang_read_lux_engine_top
    import i2crl_pkg::*;
#(
    parameter int MAX_READ_BYTES = MAX_READ_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word
);

    localparam int CW = $clog2(MAX_READ_BYTES + 1);
    localparam int EW = (CW > CFG_COUNT_W) ? CW : CFG_COUNT_W;

    logic [7:0]             r_dev_addr;
    logic [7:0]             r_reg_idx;
    logic [CFG_COUNT_W-1:0] r_read_cnt;
    logic [15:0]            r_wait_ph;

    t_seq             r_seq, n_seq;
    logic [1:0]       r_phase, n_phase;
    logic [3:0]       r_bit, n_bit;
    logic [CW-1:0]    r_byte, n_byte;
    logic [7:0]       r_shift, n_shift;
    logic [15:0]      r_wait, n_wait;
    logic             r_scl, n_scl;
    logic             r_sda, n_sda;
    logic [LUX_W-1:0] r_q;
    logic [2:0]       r_rem;
    logic             r_pend_v, n_pend_v;
    logic [7:0]       r_pend_byte;
    logic [1:0]       r_pend_pos;
    logic             r_out_valid;
    t_out_word        r_out_word, n_word;

    logic          in_fire;
    logic          arm;
    logic [EW-1:0] rc_ext;
    logic [EW-1:0] eff_cnt;
    logic          last;
    logic [7:0]    tx_byte;
    logic          tx_bit;
    logic [1:0]    phase_adv;
    logic [15:0]   wait_inc;
    t_lux_term     term;
    logic [3:0]    rem_sum;
    logic          rem_carry;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_fire     = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        rc_ext = EW'(r_read_cnt);
        if (rc_ext < EW'(READ_MIN)) begin
            eff_cnt = EW'(READ_MIN);
        end else if (rc_ext > EW'(MAX_READ_BYTES)) begin
            eff_cnt = EW'(MAX_READ_BYTES);
        end else begin
            eff_cnt = rc_ext;
        end
        last = ({1'b0, EW'(r_byte)} + {{EW{1'b0}}, 1'b1}) >= {1'b0, eff_cnt};
    end

    always_comb begin
        case (r_seq)
            SEQ_WADDR: tx_byte = r_dev_addr;
            SEQ_REG:   tx_byte = r_reg_idx;
            default:   tx_byte = r_dev_addr + 8'd1;
        endcase
        tx_bit    = r_bit[3] ? 1'b1 : tx_byte[3'd7 - r_bit[2:0]];
        phase_adv = (r_phase >= 2'd2) ? 2'd0 : r_phase + 2'd1;
        wait_inc  = r_wait + 16'd1;
    end

    always_comb begin
        n_seq    = r_seq;
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_byte   = r_byte;
        n_shift  = r_shift;
        n_wait   = r_wait;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_pend_v = 1'b0;
        arm      = 1'b0;
        n_word   = '0;

        if (i_in_word.op == OP_START) begin
            if (r_seq == SEQ_IDLE) begin
                arm     = 1'b1;
                n_seq   = SEQ_START;
                n_phase = 2'd0;
                n_bit   = 4'd0;
                n_byte  = '0;
                n_shift = 8'd0;
                n_wait  = 16'd0;
                n_scl   = 1'b1;
                n_sda   = 1'b1;
            end
        end else begin
            unique case (r_seq)
                SEQ_START, SEQ_RSTART: begin
                    n_phase = phase_adv;
                    if (r_phase == 2'd0) begin
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                    end else if (r_phase == 2'd1) begin
                        n_scl = 1'b1;
                        n_sda = 1'b0;
                    end else begin
                        n_scl = 1'b0;
                        n_sda = 1'b0;
                        n_seq = (r_seq == SEQ_START) ? SEQ_WADDR : SEQ_RADDR;
                        n_bit = 4'd0;
                    end
                end
                SEQ_WADDR, SEQ_REG, SEQ_RADDR: begin
                    n_phase = phase_adv;
                    n_scl   = (r_phase == 2'd1);
                    n_sda   = tx_bit;
                    if (r_phase >= 2'd2) begin
                        if (!r_bit[3]) begin
                            n_bit = r_bit + 4'd1;
                        end else begin
                            n_bit = 4'd0;
                            if (r_seq == SEQ_WADDR) begin
                                n_seq = SEQ_REG;
                            end else if (r_seq == SEQ_REG) begin
                                n_seq = SEQ_RSTART;
                            end else begin
                                n_wait = 16'd0;
                                n_seq  = (r_wait_ph == 16'd0) ? SEQ_READ : SEQ_WAIT;
                            end
                        end
                    end
                end
                SEQ_WAIT: begin
                    n_scl  = 1'b0;
                    n_sda  = 1'b1;
                    n_wait = wait_inc;
                    if (wait_inc >= r_wait_ph) begin
                        n_seq   = SEQ_READ;
                        n_bit   = 4'd0;
                        n_phase = 2'd0;
                    end
                end
                SEQ_READ: begin
                    n_phase = phase_adv;
                    n_scl   = (r_phase == 2'd1);
                    if (!r_bit[3]) begin
                        n_sda = 1'b1;
                        if (r_phase == 2'd1) begin
                            n_shift = {r_shift[6:0], i_in_word.sda_in};
                        end
                        if (r_phase >= 2'd2) begin
                            if (r_bit[2:0] == 3'd7) begin
                                n_word.byte_valid = 1'b1;
                                n_word.rx_byte    = r_shift;
                                n_pend_v = (EW'(r_byte) < EW'(WORD_BYTES));
                            end
                            n_bit = r_bit + 4'd1;
                        end
                    end else begin
                        n_sda = last;
                        if (r_phase >= 2'd2) begin
                            n_bit = 4'd0;
                            if (last) begin
                                n_seq = SEQ_STOP;
                            end else begin
                                n_byte = r_byte + CW'(1);
                            end
                        end
                    end
                end
                SEQ_STOP: begin
                    n_phase = phase_adv;
                    if (r_phase == 2'd0) begin
                        n_scl = 1'b0;
                        n_sda = 1'b0;
                    end else if (r_phase == 2'd1) begin
                        n_scl = 1'b1;
                        n_sda = 1'b0;
                    end else begin
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                        n_seq = SEQ_IDLE;
                        n_word.lux_valid = 1'b1;
                        n_word.lux_value = r_q;
                    end
                end
                default: begin
                    n_seq   = SEQ_IDLE;
                    n_phase = 2'd0;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
            endcase
        end

        n_word.scl_level = n_scl;
        n_word.sda_level = n_sda;
        n_word.busy_res  = (n_seq != SEQ_IDLE);
    end

    // lux accumulate: word*7 = 5*q + rem
    always_comb begin
        term      = lux_term(r_pend_byte, r_pend_pos);
        rem_sum   = {1'b0, r_rem} + {1'b0, term.rem};
        rem_carry = (rem_sum >= 4'd5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 8'd0;
            r_reg_idx  <= 8'd0;
            r_read_cnt <= CFG_COUNT_W'(129);
            r_wait_ph  <= 16'd200;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEV_ADDR: r_dev_addr <= i_cfg_data[7:0];
                CFG_REG_IDX:  r_reg_idx  <= i_cfg_data[7:0];
                CFG_READ_CNT: r_read_cnt <= i_cfg_data[CFG_COUNT_W-1:0];
                CFG_WAIT_PH:  r_wait_ph  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= SEQ_IDLE;
            r_phase  <= 2'd0;
            r_bit    <= 4'd0;
            r_byte   <= '0;
            r_shift  <= 8'd0;
            r_wait   <= 16'd0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_pend_v <= 1'b0;
        end else begin
            r_pend_v <= in_fire & n_pend_v;
            if (in_fire) begin
                r_seq   <= n_seq;
                r_phase <= n_phase;
                r_bit   <= n_bit;
                r_byte  <= n_byte;
                r_shift <= n_shift;
                r_wait  <= n_wait;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && n_pend_v) begin
            r_pend_byte <= r_shift;
            r_pend_pos  <= r_byte[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q   <= '0;
            r_rem <= 3'd0;
        end else if (in_fire && arm) begin
            r_q   <= '0;
            r_rem <= 3'd0;
        end else if (r_pend_v) begin
            r_q   <= r_q + term.add + {{(LUX_W-1){1'b0}}, rem_carry};
            r_rem <= rem_carry ? 3'(rem_sum - 4'd5) : rem_sum[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_word <= n_word;
        end
    end

endmodule

// ----- sv/i2crl_checker.sv -----
// port-level checks on the result channel of the i2c read engine
// uses i2crl_pkg and i2c_bitbang_read_lux_engine_top_macros.svh; bound to the top level
`include "i2c_bitbang_read_lux_engine_top_macros.svh"

module i2crl_checker
    import i2crl_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_word i_out_word
);

    logic quiet_ok;
    logic lux_lines_ok;
    logic byte_lines_ok;

    assign quiet_ok      = (i_out_word.byte_valid || i_out_word.rx_byte == 8'd0)
                           && (i_out_word.lux_valid || i_out_word.lux_value == '0);
    assign lux_lines_ok  = !i_out_word.busy_res && i_out_word.scl_level
                           && i_out_word.sda_level && !i_out_word.byte_valid;
    assign byte_lines_ok = i_out_word.busy_res && !i_out_word.scl_level
                           && i_out_word.sda_level;

    // a stalled result word holds
    `I2CRL_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_word))

    // no stray byte or lux payload
    `I2CRL_ASSERT_NOW(a_quiet_fields, i_out_valid, quiet_ok)

    // lux is reported on the stop edge with both lines released
    `I2CRL_ASSERT_NOW(a_lux_stop, i_out_valid && i_out_word.lux_valid, lux_lines_ok)

    // a byte completes mid-transaction with the clock held low
    `I2CRL_ASSERT_NOW(a_byte_phase, i_out_valid && i_out_word.byte_valid, byte_lines_ok)

endmodule

bind i2c_bitbang_read_lux_engine_top i2crl_checker u_i2crl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_word  (o_out_word)
);
